// ===== rtl/queue_promote_max_to_front_defines.svh =====
// Assertion helpers for the RTL, included by queue_promote_max_to_front.
`ifndef QUEUE_PROMOTE_MAX_TO_FRONT_DEFINES_SVH
`define QUEUE_PROMOTE_MAX_TO_FRONT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define QPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define QPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/qpm_pkg.sv =====
package qpm_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int POS_W       = 4;
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_PROMOTE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
    logic [POS_W-1:0]   position;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [4:0]         count;
    logic [1:0]         status;
  } out_word_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   addr;
    logic signed [31:0] data;
  } mem_wr_t;

endpackage

// ===== rtl/qpm_mem.sv =====
module qpm_mem (
  input  logic                      clk,
  input  qpm_pkg::mem_wr_t          wr,
  input  logic [qpm_pkg::IDX_W-1:0] raddr,
  output logic signed [31:0]        rdata
);

  logic signed [31:0] mem [qpm_pkg::QUEUE_DEPTH];
  logic signed [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/queue_promote_max_to_front.sv =====
// Channel | Ports                          | Word
// input   | in_valid, in_stall, in_data    | opcode, value, position
// result  | out_valid, out_stall, out_data | read_value, count, status
//
// One item at a time, one result word each. Push, errors and ignored words go from
// S_IDLE to S_FIN, read via S_READ; promote scans n entries in S_SCAN, then for a
// first maximum at index b above zero shifts b entries in S_SHIFT and writes it to
// the front in S_PUT, as the entry memory has one read and one write port. A
// held result word does not block a new item; it waits in S_FIN for out_data_r.
// Synchronous active-low reset empties the queue; entry contents are not cleared.
module queue_promote_max_to_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  qpm_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output qpm_pkg::out_word_t out_data
);

  `include "queue_promote_max_to_front_defines.svh"

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_SHIFT,
    S_PUT,
    S_FIN
  } state_t;

  state_t                    state_r, state_nxt;
  logic [qpm_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [qpm_pkg::IDX_W-1:0] k_r, k_nxt;
  logic [qpm_pkg::IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic signed [31:0]        best_val_r, best_val_nxt;
  logic signed [31:0]        res_val_r, res_val_nxt;
  logic [1:0]                res_st_r, res_st_nxt;
  logic                      out_valid_r, out_valid_nxt;
  qpm_pkg::out_word_t        out_data_r, out_data_nxt;

  qpm_pkg::mem_wr_t          wr;
  logic [qpm_pkg::IDX_W-1:0] raddr;
  logic signed [31:0]        rdata;

  logic                      take;
  logic [qpm_pkg::IDX_W-1:0] sel_idx;
  logic signed [31:0]        sel_val;
  logic                      full;
  logic                      empty;
  logic                      pos_bad;

  qpm_mem u_mem (
    .clk   (clk),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign full    = (count_r >= qpm_pkg::CNT_W'(qpm_pkg::QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign pos_bad = (qpm_pkg::CMP_W'(in_data.position) >= qpm_pkg::CMP_W'(count_r));

  // First entry seeds the maximum; later ones replace it only when strictly larger.
  assign take    = (k_r == '0) || (rdata > best_val_r);
  assign sel_idx = take ? k_r : best_idx_r;
  assign sel_val = take ? rdata : best_val_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    best_idx_nxt  = best_idx_r;
    best_val_nxt  = best_val_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr            = '0;
    raddr         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_val_nxt = '0;
          res_st_nxt  = qpm_pkg::ST_OK;
          state_nxt   = S_FIN;
          case (in_data.opcode)
            qpm_pkg::OP_PUSH: begin
              if (full) begin
                res_st_nxt = qpm_pkg::ST_FULL;
              end else begin
                wr.we     = 1'b1;
                wr.addr   = qpm_pkg::IDX_W'(count_r);
                wr.data   = in_data.value;
                count_nxt = count_r + qpm_pkg::CNT_W'(1);
              end
            end
            qpm_pkg::OP_PROMOTE: begin
              if (empty) begin
                res_st_nxt = qpm_pkg::ST_EMPTY;
              end else begin
                raddr     = '0;
                k_nxt     = '0;
                state_nxt = S_SCAN;
              end
            end
            qpm_pkg::OP_READ: begin
              if (empty) begin
                res_st_nxt = qpm_pkg::ST_EMPTY;
              end else if (pos_bad) begin
                res_st_nxt = qpm_pkg::ST_RANGE;
              end else begin
                raddr     = qpm_pkg::IDX_W'(in_data.position);
                state_nxt = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        res_val_nxt = rdata;
        state_nxt   = S_FIN;
      end
      S_SCAN: begin
        best_idx_nxt = sel_idx;
        best_val_nxt = sel_val;
        raddr        = k_r + qpm_pkg::IDX_W'(1);
        if (qpm_pkg::CNT_W'(k_r) == count_r - qpm_pkg::CNT_W'(1)) begin
          if (sel_idx == '0) begin
            res_val_nxt = sel_val;
            state_nxt   = S_FIN;
          end else begin
            raddr     = sel_idx - qpm_pkg::IDX_W'(1);
            state_nxt = S_SHIFT;
          end
        end else begin
          k_nxt = k_r + qpm_pkg::IDX_W'(1);
        end
      end
      S_SHIFT: begin
        // move entry below back by one, fetch the next one down
        wr.we        = 1'b1;
        wr.addr      = best_idx_r;
        wr.data      = rdata;
        raddr        = best_idx_r - qpm_pkg::IDX_W'(2);
        best_idx_nxt = best_idx_r - qpm_pkg::IDX_W'(1);
        if (best_idx_r == qpm_pkg::IDX_W'(1)) begin
          state_nxt = S_PUT;
        end
      end
      S_PUT: begin
        wr.we       = 1'b1;
        wr.addr     = '0;
        wr.data     = best_val_r;
        res_val_nxt = best_val_r;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.read_value = res_val_r;
          out_data_nxt.count      = 5'(count_r);
          out_data_nxt.status     = res_st_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r        <= k_nxt;
    best_idx_r <= best_idx_nxt;
    best_val_r <= best_val_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  `QPM_ASSERT_NOW(a_count_bound, 1'b1, count_r <= qpm_pkg::CNT_W'(qpm_pkg::QUEUE_DEPTH), "count above depth")
  `QPM_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != S_IDLE, "accepted word left block idle")
  `QPM_ASSERT_NOW(a_idle_write, state_r == S_IDLE && wr.we, in_valid && in_data.opcode == qpm_pkg::OP_PUSH, "idle write without push")
  `QPM_ASSERT_NOW(a_shift_ports, state_r == S_SHIFT, wr.addr != raddr, "shift reads the entry it writes")

endmodule

// ===== tb/queue_result_checker.sv =====
`timescale 1ns / 1ps

module queue_result_checker
  import qpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_word_t out_data,
  output int        fail_count,
  output int        pending
);

  logic signed [31:0] shadow_entries [QUEUE_DEPTH];
  int                 shadow_count;
  out_word_t          expected_words [$];

  function automatic out_word_t predict_queue_op(in_word_t w);
    out_word_t          r;
    int                 best;
    logic signed [31:0] top_val;
    r = '0;
    r.status = ST_OK;
    case (w.opcode)
      OP_PUSH: begin
        if (shadow_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = w.value;
          shadow_count++;
        end
      end
      OP_PROMOTE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // first occurrence of the maximum wins; ties keep the earlier index
          best = 0;
          for (int i = 1; i < shadow_count; i++) begin
            if (shadow_entries[i] > shadow_entries[best]) best = i;
          end
          top_val = shadow_entries[best];
          for (int i = best; i > 0; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[0] = top_val;
          r.read_value = top_val;
        end
      end
      OP_READ: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(w.position) >= shadow_count) begin
          r.status = ST_RANGE;
        end else begin
          r.read_value = shadow_entries[w.position];
        end
      end
      default: begin
      end
    endcase
    r.count = shadow_count[4:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      shadow_count = 0;
      expected_words.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      // check the result before queuing a new word; a result never leaves in its own cycle
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: result word %h with nothing expected", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_words.pop_front();
          if (want !== out_data) begin
            if (want.read_value !== out_data.read_value)
              $display("%0t: read_value expected %h actual %h", $time,
                       want.read_value, out_data.read_value);
            if (want.count !== out_data.count)
              $display("%0t: count expected %0d actual %0d", $time,
                       want.count, out_data.count);
            if (want.status !== out_data.status)
              $display("%0t: status expected %0d actual %0d", $time,
                       want.status, out_data.status);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) expected_words.push_back(predict_queue_op(in_data));
      pending <= expected_words.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import qpm_pkg::*;

  localparam logic [1:0] OP_IGNORED     = 2'd3;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         PHASE_ITEMS    = 430;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_word_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_data;

  int fail_count;
  int pending;
  int idle_cycles     = 0;
  int sender_idle_pct = 0;
  int recv_idle_pct   = 0;

  // stimulus-side bookkeeping: how full the queue is and the largest value pushed
  int                 filled         = 0;
  logic signed [31:0] largest_pushed = 32'sh80000000;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  queue_promote_max_to_front u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  queue_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic [1:0] op, input logic signed [31:0] val,
                           input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, value: val, position: pos};
    do @(posedge clk); while (in_stall);
    if (op == OP_PUSH && filled < QUEUE_DEPTH) begin
      filled++;
      if (val > largest_pushed) largest_pushed = val;
    end
  endtask

  // hold the sender off until every outstanding result has arrived
  task automatic wait_for_drain();
    do begin
      in_valid <= 1'b0;
      @(posedge clk);
    end while (pending != 0);
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct, input int n);
    int                 sel;
    logic               promote_next;
    logic signed [31:0] v;
    promote_next = 1'b0;
    wait_for_drain();
    sender_idle_pct = snd_pct;
    recv_idle_pct <= rcv_pct;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(99);
      if (promote_next) begin
        // the maximum sits at the tail of a full queue: deepest shift
        send_word(OP_PROMOTE, $urandom, POS_W'($urandom_range(15)));
        promote_next = 1'b0;
      end else if (filled < QUEUE_DEPTH - 1) begin
        if (sel < 35) begin
          case ($urandom_range(2))
            0: v = (largest_pushed < 32'sh7FFF0000) ?
                   largest_pushed + $urandom_range(1, 65535) : $urandom;
            1: v = largest_pushed;
            default: v = $urandom;
          endcase
          send_word(OP_PUSH, v, POS_W'($urandom_range(15)));
        end else if (sel < 60) begin
          send_word(OP_PROMOTE, $urandom, POS_W'($urandom_range(15)));
        end else if (sel < 90) begin
          send_word(OP_READ, $urandom,
                    POS_W'($urandom_range(1) ? $urandom_range(filled) :
                                               $urandom_range(15)));
        end else begin
          send_word(OP_IGNORED, $urandom, POS_W'($urandom_range(15)));
        end
      end else if (filled == QUEUE_DEPTH - 1 && sel < 35) begin
        send_word(OP_PUSH, 32'sh7FFFFFFF, POS_W'($urandom_range(15)));
        promote_next = 1'b1;
      end else if (sel < 15) begin
        send_word(OP_PUSH, $urandom, POS_W'($urandom_range(15)));
      end else if (sel < 40) begin
        send_word(OP_PROMOTE, $urandom, POS_W'($urandom_range(15)));
      end else if (sel < 85) begin
        send_word(OP_READ, $urandom, POS_W'($urandom_range(15)));
      end else begin
        send_word(OP_IGNORED, $urandom, POS_W'($urandom_range(15)));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // empty queue
    send_word(OP_READ, 32'sh0, 4'd0);
    send_word(OP_PROMOTE, 32'sh0, 4'd0);
    send_word(OP_IGNORED, 32'shFFFFFFFF, 4'd15);

    // two equal maxima: only the one nearer the front moves
    send_word(OP_PUSH, 32'sh80000000, 4'd0);
    send_word(OP_PUSH, 32'sh00010000, 4'd15);
    send_word(OP_PUSH, 32'sh00000000, 4'd0);
    send_word(OP_PUSH, 32'sh00010000, 4'd0);
    send_word(OP_PUSH, 32'shFFFFFFFF, 4'd0);
    send_word(OP_PROMOTE, 32'sh0, 4'd0);
    send_word(OP_READ, 32'sh0, 4'd0);
    send_word(OP_READ, 32'sh0, 4'd1);
    send_word(OP_READ, 32'sh0, 4'd3);
    send_word(OP_READ, 32'sh0, 4'd4);
    send_word(OP_READ, 32'sh0, 4'd5);
    send_word(OP_READ, 32'shFFFFFFFF, 4'd15);
    send_word(OP_PROMOTE, 32'sh0, 4'd0);

    run_phase(22, 50, PHASE_ITEMS);
    run_phase(50, 22, PHASE_ITEMS);
    run_phase(0, 0, PHASE_ITEMS);

    wait_for_drain();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== queue_promote_max_to_front.f =====
+incdir+rtl
rtl/qpm_pkg.sv
rtl/qpm_mem.sv
rtl/queue_promote_max_to_front.sv
tb/queue_result_checker.sv
tb/tb.sv
